### rtl/ppsu_pkg.sv
// Shared types, constants and helpers for the periodic poll rule scheduler.
// No dependencies; every other file but ppsu_ram imports this package.
package ppsu_pkg;

  localparam int MAX_RULES_DEF = 16;
  localparam int SLOT_W        = 4;
  localparam int FC_W          = 8;
  localparam int WORD_W        = 16;
  localparam int STATUS_W      = 3;

  localparam logic [FC_W-1:0] FC_READ_HOLDING = 8'h03;
  localparam logic [FC_W-1:0] FC_READ_INPUT   = 8'h04;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_SELECTED = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  // One table row as stored in the rule RAM
  typedef struct packed {
    logic [FC_W-1:0]   fn;
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] period;
    logic [WORD_W-1:0] countdown;
  } rule_row_t;

  typedef struct packed {
    logic load;    // capture the accepted item, rewind the table walk
    logic issue;   // read the next table row
    logic finish;  // apply the item and load the result register
  } ppsu_cmd_t;

  typedef struct packed {
    logic table_empty;
    logic last_issue;
    logic out_free;
  } ppsu_sts_t;

  function automatic logic is_read_fc(input logic [FC_W-1:0] fc);
    return (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
  endfunction

endpackage

### rtl/ppsu_if.sv
// Valid/ready channel interfaces for item input, result output and configuration.
// Depends on ppsu_pkg for field widths.
interface ppsu_in_if import ppsu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [FC_W-1:0]   function_code;
  logic [WORD_W-1:0] start_address;
  logic [WORD_W-1:0] register_count;
  logic [WORD_W-1:0] poll_period;
  logic [WORD_W-1:0] elapsed_ticks;

  modport source (output valid, opcode, function_code, start_address, register_count,
                  poll_period, elapsed_ticks, input ready);
  modport sink   (input valid, opcode, function_code, start_address, register_count,
                  poll_period, elapsed_ticks, output ready);
endinterface

interface ppsu_out_if import ppsu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [FC_W-1:0]     function_code_out;
  logic [WORD_W-1:0]   start_address_out;
  logic [WORD_W-1:0]   register_count_out;

  modport source (output valid, status, slot, function_code_out, start_address_out,
                  register_count_out, input ready);
  modport sink   (input valid, status, slot, function_code_out, start_address_out,
                  register_count_out, output ready);
endinterface

interface ppsu_cfg_if;
  logic valid;
  logic ready;
  logic timer_enabled;

  modport source (output valid, timer_enabled, input ready);
  modport sink   (input valid, timer_enabled, output ready);
endinterface

### rtl/ppsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ppsu_ctrl.sv
// Sequencer for the scheduler: accepts an item, walks the rule table, finishes.
// Depends on ppsu_pkg for the command and status structs.
module ppsu_ctrl import ppsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ppsu_sts_t sts,
  output ppsu_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = sts.table_empty ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      // last row read is processed here
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

### rtl/ppsu_dp.sv
// Datapath: rule RAM, table walk pipeline, cursors, result register.
// Depends on ppsu_pkg and ppsu_ram.
module ppsu_dp import ppsu_pkg::*; #(
  parameter int MAX_RULES = MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppsu_cmd_t           cmd,
  output ppsu_sts_t           sts,
  input  logic                cfg_valid,
  input  logic                cfg_timer_enabled,
  input  logic                in_opcode,
  input  logic [FC_W-1:0]     in_function_code,
  input  logic [WORD_W-1:0]   in_start_address,
  input  logic [WORD_W-1:0]   in_register_count,
  input  logic [WORD_W-1:0]   in_poll_period,
  input  logic [WORD_W-1:0]   in_elapsed_ticks,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [FC_W-1:0]     out_function_code,
  output logic [WORD_W-1:0]   out_start_address,
  output logic [WORD_W-1:0]   out_register_count
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int ROW_W = $bits(rule_row_t);

  // item latch
  logic              op_r;
  logic [FC_W-1:0]   fc_r;
  logic [WORD_W-1:0] sa_r, rc_r, pp_r, el_r;

  logic             timer_en_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] tcur_r, ucur_r;

  // table walk
  logic [IDX_W-1:0] rd_ptr_r;
  logic             pv_r;
  logic [IDX_W-1:0] p_r;

  logic             dup_found_r, hi_found_r, any_found_r;
  logic [IDX_W-1:0] dup_idx_r, hi_idx_r, any_idx_r;
  logic [FC_W-1:0]   hi_fn_r, any_fn_r;
  logic [WORD_W-1:0] hi_sa_r, hi_rc_r, any_sa_r, any_rc_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [FC_W-1:0]     out_fc_r;
  logic [WORD_W-1:0]   out_sa_r, out_rc_r;

  rule_row_t        rd_row, wr_row;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_rdata;

  ppsu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_RULES)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_row),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign rd_row = rule_row_t'(ram_rdata);

  // row processing
  logic             row_is_read, row_match, row_hit, lo_ok;
  logic [IDX_W-1:0] ucur_eff, lo_bound;
  logic [WORD_W-1:0] cd_dec;

  always_comb begin
    ucur_eff    = (CNT_W'(ucur_r) >= n_r) ? '0 : ucur_r;
    lo_bound    = timer_en_r ? tcur_r : ucur_eff;
    lo_ok       = (p_r >= lo_bound);
    row_is_read = is_read_fc(rd_row.fn);
    row_match   = (rd_row.fn == fc_r) && (rd_row.start == sa_r) && (rd_row.span == rc_r);
    cd_dec      = (rd_row.countdown <= el_r) ? '0 : (rd_row.countdown - el_r);
    // timed: due at or past the cursor; untimed: any read rule at or past the cursor
    row_hit     = row_is_read && lo_ok && !hi_found_r &&
                  (!timer_en_r || (cd_dec == '0));
  end

  // finish stage
  logic             add_ok, sel_found;
  logic [IDX_W-1:0] sel_idx, sel_next;
  logic [CNT_W-1:0] sel_inc;
  logic [FC_W-1:0]   sel_fn;
  logic [WORD_W-1:0] sel_sa, sel_rc;

  always_comb begin
    add_ok    = !dup_found_r && (n_r < CNT_W'(MAX_RULES));
    sel_found = hi_found_r || (!timer_en_r && any_found_r);
    sel_idx   = hi_found_r ? hi_idx_r : any_idx_r;
    sel_fn    = hi_found_r ? hi_fn_r : any_fn_r;
    sel_sa    = hi_found_r ? hi_sa_r : any_sa_r;
    sel_rc    = hi_found_r ? hi_rc_r : any_rc_r;
    sel_inc   = CNT_W'(sel_idx) + CNT_W'(1);
    sel_next  = (sel_inc == n_r) ? '0 : IDX_W'(sel_inc);
  end

  // RAM write: countdown update during a timed walk, new row on add
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_r;
    wr_row    = rd_row;
    if (cmd.finish) begin
      ram_we           = !op_r && add_ok;
      ram_waddr        = IDX_W'(n_r);
      wr_row.fn        = fc_r;
      wr_row.start     = sa_r;
      wr_row.span      = rc_r;
      wr_row.period    = pp_r;
      wr_row.countdown = pp_r;
    end else if (pv_r && op_r && timer_en_r && row_is_read) begin
      ram_we           = 1'b1;
      wr_row.countdown = row_hit ? rd_row.period : cd_dec;
    end
  end

  assign sts.table_empty = (n_r == '0);
  assign sts.last_issue  = (CNT_W'(rd_ptr_r) == (n_r - CNT_W'(1)));
  assign sts.out_free    = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_en_r  <= 1'b1;
      n_r         <= '0;
      tcur_r      <= '0;
      ucur_r      <= '0;
      rd_ptr_r    <= '0;
      pv_r        <= 1'b0;
      dup_found_r <= 1'b0;
      hi_found_r  <= 1'b0;
      any_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timer_en_r <= cfg_timer_enabled;
      end
      pv_r <= cmd.issue;
      if (cmd.load) begin
        rd_ptr_r    <= '0;
        dup_found_r <= 1'b0;
        hi_found_r  <= 1'b0;
        any_found_r <= 1'b0;
      end else if (cmd.issue) begin
        rd_ptr_r <= rd_ptr_r + IDX_W'(1);
      end
      if (pv_r) begin
        if (!op_r) begin
          if (row_match && !dup_found_r) dup_found_r <= 1'b1;
        end else begin
          if (row_hit) hi_found_r <= 1'b1;
          if (row_is_read && !timer_en_r) any_found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (!op_r) begin
          if (add_ok) n_r <= n_r + CNT_W'(1);
        end else if (timer_en_r) begin
          tcur_r <= hi_found_r ? sel_next : '0;
        end else if (sel_found) begin
          ucur_r <= sel_next;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      fc_r <= in_function_code;
      sa_r <= in_start_address;
      rc_r <= in_register_count;
      pp_r <= in_poll_period;
      el_r <= in_elapsed_ticks;
    end
    p_r <= rd_ptr_r;
    if (pv_r) begin
      if (row_match && !dup_found_r) dup_idx_r <= p_r;
      if (row_hit) begin
        hi_idx_r <= p_r;
        hi_fn_r  <= rd_row.fn;
        hi_sa_r  <= rd_row.start;
        hi_rc_r  <= rd_row.span;
      end
      if (row_is_read && !any_found_r) begin
        any_idx_r <= p_r;
        any_fn_r  <= rd_row.fn;
        any_sa_r  <= rd_row.start;
        any_rc_r  <= rd_row.span;
      end
    end
    if (cmd.finish) begin
      out_fc_r <= '0;
      out_sa_r <= '0;
      out_rc_r <= '0;
      if (!op_r) begin
        priority if (dup_found_r) begin
          out_status_r <= ST_DUP;
          out_slot_r   <= SLOT_W'(dup_idx_r);
        end else if (!add_ok) begin
          out_status_r <= ST_FULL;
          out_slot_r   <= '0;
        end else begin
          out_status_r <= ST_ADDED;
          out_slot_r   <= SLOT_W'(n_r);
        end
      end else if (sel_found) begin
        out_status_r <= ST_SELECTED;
        out_slot_r   <= SLOT_W'(sel_idx);
        out_fc_r     <= sel_fn;
        out_sa_r     <= sel_sa;
        out_rc_r     <= sel_rc;
      end else begin
        out_status_r <= ST_NONE;
        out_slot_r   <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_function_code  = out_fc_r;
  assign out_start_address  = out_sa_r;
  assign out_register_count = out_rc_r;

  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_RULES))
    else $error("rule count exceeds table depth");

  a_cursors_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ((tcur_r == '0) || (CNT_W'(tcur_r) < n_r)) &&
    ((ucur_r == '0) || (CNT_W'(ucur_r) < n_r)))
    else $error("poll cursor points past the table");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result raised without a finish command");

  a_walk_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !sts.table_empty)
    else $error("table walk on an empty table");

endmodule

### rtl/periodic_poll_rule_scheduler_unit.sv
// Top level of the periodic poll rule scheduler: controller, datapath, channel wiring.
// Depends on ppsu_pkg, ppsu_if, ppsu_ctrl and ppsu_dp.
//
// Holds up to MAX_RULES bus poll rules in one RAM and answers each item with exactly
// one result. Both add and poll items walk the whole table through the RAM's single
// read port, one row per cycle. An accepted item is latched, its rows are read in the
// scan state, the last row read is processed in the drain state, and the finish state
// loads the output register. An empty table skips the walk and goes straight to the
// finish state. One item is in work at a time. A finished result waits in the output
// register while the next item is accepted and walked; that item holds in its last
// cycle until the register is free. The table needs no clearing pass after reset: only
// rows below the rule count are ever read. The timer mode register is written through
// cfg_ch, which is always ready; the user must write it only while no item is in work,
// and the block itself does not enforce this.
module periodic_poll_rule_scheduler_unit import ppsu_pkg::*; #(
  parameter int MAX_RULES = MAX_RULES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ppsu_in_if.sink     in_ch,
  ppsu_out_if.source  out_ch,
  ppsu_cfg_if.sink    cfg_ch
);

  ppsu_cmd_t cmd;
  ppsu_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  ppsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppsu_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_ch.valid),
    .cfg_timer_enabled  (cfg_ch.timer_enabled),
    .in_opcode          (in_ch.opcode),
    .in_function_code   (in_ch.function_code),
    .in_start_address   (in_ch.start_address),
    .in_register_count  (in_ch.register_count),
    .in_poll_period     (in_ch.poll_period),
    .in_elapsed_ticks   (in_ch.elapsed_ticks),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_slot           (out_ch.slot),
    .out_function_code  (out_ch.function_code_out),
    .out_start_address  (out_ch.start_address_out),
    .out_register_count (out_ch.register_count_out)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for periodic_poll_rule_scheduler_unit: a table of directed items, then
// random add/poll traffic in both timer modes, set per phase, checked against a behavioral table model.
// Depends on ppsu_pkg, the ppsu_if channel interfaces and the RTL top level.
module testbench import ppsu_pkg::*; ();

  localparam logic OP_ADD       = 1'b0;
  localparam logic OP_POLL      = 1'b1;
  localparam int   TABLE_DEPTH  = 16;
  localparam int   PHASE_ITEMS  = 250;
  localparam int   PHASES       = 7;
  localparam logic [PHASES-1:0] TIMER_PLAN = 7'b1011010;
  localparam int   SETTLE_CYCLES = 25;
  localparam int   HOLD_CYCLES   = 400;
  localparam int   STALL_LIMIT   = 3000;

  typedef struct packed {
    logic              op;
    logic [FC_W-1:0]   fc;
    logic [WORD_W-1:0] sa;
    logic [WORD_W-1:0] rc;
    logic [WORD_W-1:0] pp;
    logic [WORD_W-1:0] el;
  } sched_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [FC_W-1:0]     fc;
    logic [WORD_W-1:0]   sa;
    logic [WORD_W-1:0]   rc;
  } sched_result_t;

  typedef enum logic { ROW_ITEM, ROW_TIMER } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    sched_item_t   item;
    logic          timer_val;
    logic          typed;
    sched_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ppsu_in_if  in_ch ();
  ppsu_out_if out_ch ();
  ppsu_cfg_if cfg_ch ();

  periodic_poll_rule_scheduler_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rule table as the block should hold it
  logic [FC_W-1:0]   tb_fn        [TABLE_DEPTH];
  logic [WORD_W-1:0] tb_start     [TABLE_DEPTH];
  logic [WORD_W-1:0] tb_span      [TABLE_DEPTH];
  logic [WORD_W-1:0] tb_period    [TABLE_DEPTH];
  logic [WORD_W-1:0] tb_countdown [TABLE_DEPTH];
  int                rule_cnt  = 0;
  int                timed_pos = 0;
  int                rr_pos    = 0;
  logic              timer_on  = 1'b1;

  sched_result_t pending_results[$];
  int            error_count = 0;
  int            items_in    = 0;
  int            idle_cycles = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  function automatic logic polls_as_read(input int idx);
    return (tb_fn[idx] == FC_READ_HOLDING) || (tb_fn[idx] == FC_READ_INPUT);
  endfunction

  // Apply one item to the table and return the result it should produce
  function automatic sched_result_t next_schedule_result(input sched_item_t it);
    sched_result_t r;
    int i;
    int c;
    r = '0;
    if (it.op == OP_ADD) begin
      for (i = 0; i < rule_cnt; i++) begin
        if (tb_fn[i] == it.fc && tb_start[i] == it.sa && tb_span[i] == it.rc) begin
          r.status = ST_DUP;
          r.slot   = i[SLOT_W-1:0];
          return r;
        end
      end
      if (rule_cnt >= TABLE_DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      tb_fn[rule_cnt]        = it.fc;
      tb_start[rule_cnt]     = it.sa;
      tb_span[rule_cnt]      = it.rc;
      tb_period[rule_cnt]    = it.pp;
      tb_countdown[rule_cnt] = it.pp;
      r.status = ST_ADDED;
      r.slot   = rule_cnt[SLOT_W-1:0];
      rule_cnt++;
      return r;
    end
    r.status = ST_NONE;
    if (timer_on) begin
      for (i = 0; i < rule_cnt; i++) begin
        if (polls_as_read(i))
          tb_countdown[i] = (tb_countdown[i] <= it.el) ? '0 : tb_countdown[i] - it.el;
      end
      // scan toward the table end only; wrapping ends the scan
      while (timed_pos < rule_cnt) begin
        c = timed_pos;
        timed_pos = (c + 1 == rule_cnt) ? 0 : c + 1;
        if (polls_as_read(c) && tb_countdown[c] == '0) begin
          tb_countdown[c] = tb_period[c];
          r.status = ST_SELECTED;
          r.slot   = c[SLOT_W-1:0];
          r.fc     = tb_fn[c];
          r.sa     = tb_start[c];
          r.rc     = tb_span[c];
          return r;
        end
        if (timed_pos == 0)
          break;
      end
      return r;
    end
    c = rr_pos;
    if (rule_cnt != 0 && c >= rule_cnt)
      c = 0;
    for (i = 0; i < rule_cnt; i++) begin
      if (polls_as_read(c)) begin
        rr_pos   = (c + 1 >= rule_cnt) ? 0 : c + 1;
        r.status = ST_SELECTED;
        r.slot   = c[SLOT_W-1:0];
        r.fc     = tb_fn[c];
        r.sa     = tb_start[c];
        r.rc     = tb_span[c];
        return r;
      end
      c = (c + 1 >= rule_cnt) ? 0 : c + 1;
    end
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic op, input logic [FC_W-1:0] fc,
                                       input logic [WORD_W-1:0] sa, input logic [WORD_W-1:0] rc,
                                       input logic [WORD_W-1:0] pp, input logic [WORD_W-1:0] el,
                                       input logic typed, input status_t st,
                                       input logic [SLOT_W-1:0] slot);
    stim_row_t row;
    row = '0;
    row.kind        = ROW_ITEM;
    row.item.op     = op;
    row.item.fc     = fc;
    row.item.sa     = sa;
    row.item.rc     = rc;
    row.item.pp     = pp;
    row.item.el     = el;
    row.typed       = typed;
    row.want.status = st;
    row.want.slot   = slot;
    return row;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input sched_item_t it, input logic typed, input sched_result_t typed_want);
    sched_result_t want;
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= it.op;
    in_ch.function_code  <= it.fc;
    in_ch.start_address  <= it.sa;
    in_ch.register_count <= it.rc;
    in_ch.poll_period    <= it.pp;
    in_ch.elapsed_ticks  <= it.el;
    do @(posedge clk); while (!in_ch.ready);
    want = next_schedule_result(it);
    pending_results.insert(pending_results.size(), typed ? typed_want : want);
    items_in++;
    @(negedge clk);
  endtask

  // Drain, let the block go quiet, then write the mode register
  task automatic set_timer_mode(input logic on);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.timer_enabled <= on;
    do @(posedge clk); while (!cfg_ch.ready);
    timer_on = on;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no item pending", int'(out_ch.status), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status != want.status)
          flag_mismatch("status", int'(out_ch.status), int'(want.status));
        if (out_ch.slot != want.slot)
          flag_mismatch("slot", int'(out_ch.slot), int'(want.slot));
        if (out_ch.function_code_out != want.fc)
          flag_mismatch("function_code_out", int'(out_ch.function_code_out), int'(want.fc));
        if (out_ch.start_address_out != want.sa)
          flag_mismatch("start_address_out", int'(out_ch.start_address_out), int'(want.sa));
        if (out_ch.register_count_out != want.rc)
          flag_mismatch("register_count_out", int'(out_ch.register_count_out),
                        int'(want.rc));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("periodic_poll_rule_scheduler_unit regression: fail");
        $finish;
      end
    end
  end

  // Result side: a randomly picked stall pattern for each span, plus one long hold
  initial begin : result_drain
    int mode;
    int span;
    int tick;
    logic held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (tick = 0; tick < span; tick++) begin
        @(negedge clk);
        if (!held && items_in >= 600) begin
          held = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        unique case (mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= (tick % 4 != 3);
          end
          2: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ch.ready <= (tick % 8 == 0);
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    stim_row_t     directed_rows[$];
    stim_row_t     row;
    sched_item_t   it;
    logic [FC_W-1:0] fcv;
    int            phase;
    int            sent;
    int            burst;
    int            gap;
    int            k;
    int            pick;
    int            w;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_ADD;
    in_ch.function_code  = '0;
    in_ch.start_address  = '0;
    in_ch.register_count = '0;
    in_ch.poll_period    = '0;
    in_ch.elapsed_ticks  = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.timer_enabled = 1'b1;

    // Directed table: empty table, duplicates, zero period, extremes, both modes, full table
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_POLL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                1'b1, ST_NONE, 4'd0));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_ADD, FC_READ_HOLDING, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 1'b1, ST_ADDED, 4'd0));
    // same rule with another period is still a duplicate
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_ADD, FC_READ_HOLDING, 16'h0000, 16'h0000, 16'hFFFF,
                                16'hFFFF, 1'b1, ST_DUP, 4'd0));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_ADD, FC_READ_INPUT, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'h0000, 1'b1, ST_ADDED, 4'd1));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_ADD, 8'hFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h0000,
                                1'b1, ST_ADDED, 4'd2));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_ADD, FC_READ_HOLDING, 16'h0000, 16'h0001, 16'h0005,
                                16'h0000, 1'b1, ST_ADDED, 4'd3));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_POLL, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0000,
                                1'b0, ST_NONE, 4'd0));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_POLL, 8'h00, 16'h0, 16'h0, 16'h0, 16'hFFFE,
                                1'b0, ST_NONE, 4'd0));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_POLL, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                1'b0, ST_NONE, 4'd0));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_POLL, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0000,
                                1'b0, ST_NONE, 4'd0));
    row = '0;
    row.kind      = ROW_TIMER;
    row.timer_val = 1'b0;
    directed_rows.insert(directed_rows.size(), row);
    for (k = 0; k < 3; k++)
      directed_rows.insert(directed_rows.size(),
                           mk_row(OP_POLL, 8'h00, 16'h0, 16'h0, 16'h0, 16'h1234,
                                  1'b0, ST_NONE, 4'd0));
    row.timer_val = 1'b1;
    directed_rows.insert(directed_rows.size(), row);
    // fill slots 4..15; the top nibble of the address keeps them distinct
    for (k = 4; k < TABLE_DEPTH; k++) begin
      pick = $urandom_range(0, 2);
      fcv  = (pick == 0) ? FC_READ_HOLDING : (pick == 1) ? FC_READ_INPUT : FC_W'($urandom);
      directed_rows.insert(directed_rows.size(),
                           mk_row(OP_ADD, fcv, {k[3:0], 12'($urandom)},
                                  {4'h0, 12'($urandom)}, WORD_W'($urandom_range(0, 40)),
                                  16'h0000, 1'b0, ST_ADDED, 4'd0));
    end
    // full table: duplicate is still reported ahead of the full status
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_ADD, FC_READ_INPUT, 16'hFFFF, 16'hFFFF, 16'h0000,
                                16'h0000, 1'b1, ST_DUP, 4'd1));
    directed_rows.insert(directed_rows.size(),
                         mk_row(OP_ADD, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                1'b1, ST_FULL, 4'd0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_TIMER)
        set_timer_mode(directed_rows[r].timer_val);
      else
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      set_timer_mode(TIMER_PLAN[phase]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          it.fc = FC_W'($urandom);
          it.sa = WORD_W'($urandom);
          it.rc = WORD_W'($urandom);
          it.pp = WORD_W'($urandom);
          it.el = WORD_W'($urandom);
          if ($urandom_range(0, 99) < 65) begin
            it.op = OP_POLL;
            pick  = $urandom_range(0, 9);
            if (pick < 7)
              it.el = WORD_W'($urandom_range(0, 8));
            else if (pick < 9)
              it.el = WORD_W'($urandom_range(0, 64));
          end else begin
            it.op = OP_ADD;
            if ($urandom_range(0, 99) < 40)
              it.pp = WORD_W'($urandom_range(0, 40));
            // re-add a stored rule about half the time
            if ($urandom_range(0, 1) == 1 && rule_cnt != 0) begin
              pick  = $urandom_range(0, rule_cnt - 1);
              it.fc = tb_fn[pick];
              it.sa = tb_start[pick];
              it.rc = tb_span[pick];
            end
          end
          send_item(it, 1'b0, '0);
          sent++;
        end
        gap = (phase % 3 == 2) ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    in_ch.valid <= 1'b0;
    for (w = 0; w < 20000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results never delivered", pending_results.size(), 0);
    if (error_count == 0)
      $display("periodic_poll_rule_scheduler_unit regression: pass");
    else
      $display("periodic_poll_rule_scheduler_unit regression: fail");
    $finish;
  end

endmodule
